>>> hw/rtl/ppd_pkg.sv
// Shared types and constants for the peak-preserving decimator.
// Used by ppd_setup and peak_preserving_decimator; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ppd_pkg;

  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TRACE_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_INDEX  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_INDEX    = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_POINTS   = 2'd3;

  localparam int MAX_POINTS_RESET = 1024;

  typedef struct packed {
    logic ready;
    logic window_ok;
  } ppd_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/ppd_divider.sv
// Restoring divider, one quotient bit per clock.
// Stand-alone; instantiated by ppd_setup.
`timescale 1ns / 1ps
`default_nettype none

module ppd_divider #(
  parameter int DIVIDEND_BITS = 24,
  parameter int DIVISOR_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     busy,
  output logic [DIVIDEND_BITS-1:0] quotient,
  output logic [DIVISOR_BITS-1:0]  remainder
);

  localparam int COUNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [COUNT_BITS-1:0]    count;
  logic [DIVIDEND_BITS-1:0] shift_word;
  logic [DIVISOR_BITS-1:0]  partial;
  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    trial_diff;
  logic                     fits;

  assign trial      = {partial, shift_word[DIVIDEND_BITS-1]};
  assign trial_diff = trial - {1'b0, divisor};
  assign fits       = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= COUNT_BITS'(DIVIDEND_BITS);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_word <= dividend;
      partial    <= '0;
    end else if (count != '0) begin
      shift_word <= {shift_word[DIVIDEND_BITS-2:0], fits};
      partial    <= fits ? trial_diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
    end
  end

  assign busy      = count != '0;
  assign quotient  = shift_word;
  assign remainder = partial;

endmodule

`default_nettype wire

>>> hw/rtl/ppd_setup.sv
// Configuration registers and the per-window setup: clamped window, bucket count,
// step quotient and remainder, and the first bucket boundary. Uses ppd_pkg, ppd_divider.
`timescale 1ns / 1ps
`default_nettype none

module ppd_setup
  import ppd_pkg::*;
#(
  parameter int INDEX_BITS = 24,
  parameter int POINT_BITS = 16,
  parameter int CFG_BITS   = 25
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  output ppd_status_t               status,
  output logic [INDEX_BITS-1:0]     first_clamp,
  output logic [INDEX_BITS-1:0]     end_clamp,
  output logic [POINT_BITS-1:0]     buckets,
  output logic [INDEX_BITS-1:0]     step_quotient,
  output logic [POINT_BITS-1:0]     step_remainder,
  output logic [INDEX_BITS-1:0]     start_boundary,
  output logic [POINT_BITS:0]       start_remainder
);

  localparam int WIDE = (INDEX_BITS > POINT_BITS) ? INDEX_BITS : POINT_BITS;

  logic [INDEX_BITS-1:0]        trace_length;
  logic signed [INDEX_BITS:0]   first_index;
  logic signed [INDEX_BITS:0]   end_index;
  logic [POINT_BITS-1:0]        max_points;

  logic [1:0]                   settle;
  logic                         div_busy;
  logic                         div_busy_q;
  logic                         window_ok;

  logic [INDEX_BITS-1:0]        first_clamp_next;
  logic signed [INDEX_BITS:0]   end_limited;
  logic                         window_ok_next;
  logic [INDEX_BITS-1:0]        span;
  logic [INDEX_BITS-1:0]        span_next;
  logic [POINT_BITS-1:0]        buckets_next;

  logic [POINT_BITS+1:0]        start_sum;
  logic [POINT_BITS+1:0]        two_buckets;
  logic [POINT_BITS+1:0]        start_wrapped;
  logic                         start_carry;

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_length <= '0;
      first_index  <= '0;
      end_index    <= '0;
      max_points   <= POINT_BITS'(MAX_POINTS_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TRACE_LENGTH: trace_length <= cfg_data[INDEX_BITS-1:0];
        REG_FIRST_INDEX:  first_index  <= cfg_data[INDEX_BITS:0];
        REG_END_INDEX:    end_index    <= cfg_data[INDEX_BITS:0];
        REG_MAX_POINTS:   max_points   <= cfg_data[POINT_BITS-1:0];
      endcase
    end
  end

  // Window clamp, then span and bucket count, each behind a register.
  always_comb begin
    first_clamp_next = first_index[INDEX_BITS] ? '0 : first_index[INDEX_BITS-1:0];
    end_limited = (end_index > $signed({1'b0, trace_length})) ?
                  $signed({1'b0, trace_length}) : end_index;
    window_ok_next = (end_limited > $signed({1'b0, first_clamp_next})) &&
                     (max_points != '0);
    span_next = end_clamp - first_clamp;
    buckets_next = (WIDE'(max_points) < WIDE'(span)) ? max_points : POINT_BITS'(span);
  end

  always_ff @(posedge clk) begin
    first_clamp <= first_clamp_next;
    end_clamp   <= end_limited[INDEX_BITS-1:0];
    span        <= span_next;
    buckets     <= buckets_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ok  <= 1'b0;
      settle     <= 2'd3;
      div_busy_q <= 1'b0;
    end else begin
      window_ok  <= window_ok_next;
      div_busy_q <= div_busy;
      if (cfg_write) begin
        settle <= 2'd3;
      end else if (settle != 2'd0) begin
        settle <= settle - 1'b1;
      end
    end
  end

  ppd_divider #(
    .DIVIDEND_BITS (INDEX_BITS),
    .DIVISOR_BITS  (POINT_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (settle == 2'd1 && !cfg_write),
    .dividend  (span),
    .divisor   (buckets),
    .busy      (div_busy),
    .quotient  (step_quotient),
    .remainder (step_remainder)
  );

  // First boundary: start of window plus one step, remainder kept in half-bucket units.
  always_comb begin
    two_buckets   = {1'b0, buckets, 1'b0};
    start_sum     = (POINT_BITS+2)'(buckets) + (POINT_BITS+2)'({step_remainder, 1'b0});
    start_carry   = start_sum >= two_buckets;
    start_wrapped = start_carry ? (start_sum - two_buckets) : start_sum;
  end

  always_ff @(posedge clk) begin
    start_boundary  <= first_clamp + step_quotient + INDEX_BITS'(start_carry);
    start_remainder <= start_wrapped[POINT_BITS:0];
  end

  assign status.ready     = (settle == 2'd0) && !div_busy && !div_busy_q;
  assign status.window_ok = window_ok;

endmodule

`default_nettype wire

>>> hw/rtl/peak_preserving_decimator.sv
// Peak-preserving min/max decimator: top level with the per-sample datapath.
// Depends on ppd_pkg, ppd_setup and ppd_divider.
//
// Channel  Direction  Handshake                 Payload
// s_axis   in         s_axis_tvalid/tready      sample_value
// m_axis   out        m_axis_tvalid/tready      peak, bucket, min, max; tlast = last point
// cfg      in         cfg_valid/cfg_ready       register index and value
//
// One sample word is taken every clock unless the input is held off as below; a point
// appears in the cycle after the sample that closes its bucket. After reset and after
// each register write the input is held off while the setup settles and the step divider runs one bit per clock.
// A waiting point stalls the input only when the next sample would close a bucket.
// Reset is synchronous and clears the counters and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module peak_preserving_decimator
  import ppd_pkg::*;
#(
  parameter int INDEX_BITS  = 24,
  parameter int POINT_BITS  = 16,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // sample_value
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // peak_value, bucket_number, window_min, window_max
  output logic [((3*SAMPLE_BITS+POINT_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic                      m_axis_tlast,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [((INDEX_BITS+1 > POINT_BITS) ? INDEX_BITS+1 : POINT_BITS)-1:0] cfg_data
);

  localparam int CFG_BITS      = (INDEX_BITS + 1 > POINT_BITS) ? INDEX_BITS + 1 : POINT_BITS;
  localparam int OUT_DATA_BITS = ((3*SAMPLE_BITS + POINT_BITS + 7) / 8) * 8;
  localparam logic [INDEX_BITS-1:0]         CNT_MAX  = {INDEX_BITS{1'b1}};
  localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  ppd_status_t                    status;
  logic [INDEX_BITS-1:0]          first_clamp;
  logic [INDEX_BITS-1:0]          end_clamp;
  logic [POINT_BITS-1:0]          buckets;
  logic [INDEX_BITS-1:0]          div_quotient;
  logic [POINT_BITS-1:0]          div_remainder;
  logic [INDEX_BITS-1:0]          start_boundary;
  logic [POINT_BITS:0]            start_remainder;

  logic [INDEX_BITS-1:0]          sample_counter;
  logic [POINT_BITS-1:0]          bucket_counter;
  logic [INDEX_BITS-1:0]          next_boundary;
  logic [POINT_BITS:0]            boundary_remainder;
  logic [INDEX_BITS-1:0]          step_quotient;
  logic [POINT_BITS-1:0]          step_remainder;
  logic signed [SAMPLE_BITS-1:0]  bucket_low;
  logic signed [SAMPLE_BITS-1:0]  bucket_high;
  logic signed [SAMPLE_BITS-1:0]  running_min;
  logic signed [SAMPLE_BITS-1:0]  running_max;

  logic signed [SAMPLE_BITS-1:0]  peak_q;
  logic [POINT_BITS-1:0]          bucket_q;
  logic signed [SAMPLE_BITS-1:0]  window_min_q;
  logic signed [SAMPLE_BITS-1:0]  window_max_q;
  logic                           last_q;
  logic                           out_valid;

  logic                           in_window;
  logic                           window_start;
  logic                           emit_now;
  logic                           in_accept;
  logic signed [SAMPLE_BITS-1:0]  sample;

  logic [INDEX_BITS-1:0]          boundary_eff;
  logic [POINT_BITS:0]            remainder_eff;
  logic [POINT_BITS-1:0]          counter_eff;
  logic [INDEX_BITS-1:0]          quotient_eff;
  logic [POINT_BITS-1:0]          step_rem_eff;
  logic signed [SAMPLE_BITS-1:0]  low_eff;
  logic signed [SAMPLE_BITS-1:0]  high_eff;
  logic signed [SAMPLE_BITS-1:0]  rmin_eff;
  logic signed [SAMPLE_BITS-1:0]  rmax_eff;
  logic signed [SAMPLE_BITS-1:0]  low_next;
  logic signed [SAMPLE_BITS-1:0]  high_next;
  logic signed [SAMPLE_BITS-1:0]  rmin_next;
  logic signed [SAMPLE_BITS-1:0]  rmax_next;
  logic [SAMPLE_BITS:0]           high_mag;
  logic [SAMPLE_BITS:0]           low_mag;
  logic [POINT_BITS+1:0]          adv_sum;
  logic [POINT_BITS+1:0]          adv_wrapped;
  logic [POINT_BITS+1:0]          two_buckets;
  logic                           adv_carry;
  logic [POINT_BITS:0]            counter_inc;

  ppd_setup #(
    .INDEX_BITS (INDEX_BITS),
    .POINT_BITS (POINT_BITS),
    .CFG_BITS   (CFG_BITS)
  ) u_setup (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .status          (status),
    .first_clamp     (first_clamp),
    .end_clamp       (end_clamp),
    .buckets         (buckets),
    .step_quotient   (div_quotient),
    .step_remainder  (div_remainder),
    .start_boundary  (start_boundary),
    .start_remainder (start_remainder)
  );

  assign cfg_ready = 1'b1;
  assign sample    = s_axis_tdata[SAMPLE_BITS-1:0];

  always_comb begin
    in_window    = status.window_ok && (sample_counter >= first_clamp) &&
                   (sample_counter < end_clamp);
    window_start = in_window && (sample_counter == first_clamp);

    boundary_eff  = window_start ? start_boundary  : next_boundary;
    remainder_eff = window_start ? start_remainder : boundary_remainder;
    counter_eff   = window_start ? '0              : bucket_counter;
    quotient_eff  = window_start ? div_quotient    : step_quotient;
    step_rem_eff  = window_start ? div_remainder   : step_remainder;
    low_eff       = window_start ? MOST_POS        : bucket_low;
    high_eff      = window_start ? MOST_NEG        : bucket_high;
    rmin_eff      = window_start ? MOST_POS        : running_min;
    rmax_eff      = window_start ? MOST_NEG        : running_max;

    // Closing a bucket does not depend on the sample value.
    emit_now = in_window &&
               ({1'b0, sample_counter} + 1'b1 == {1'b0, boundary_eff});

    low_next  = (sample < low_eff)  ? sample : low_eff;
    high_next = (sample > high_eff) ? sample : high_eff;
    rmin_next = (low_next < rmin_eff)  ? low_next  : rmin_eff;
    rmax_next = (high_next > rmax_eff) ? high_next : rmax_eff;

    high_mag = high_next[SAMPLE_BITS-1] ? (~{1'b1, high_next} + 1'b1) : {1'b0, high_next};
    low_mag  = low_next[SAMPLE_BITS-1]  ? (~{1'b1, low_next} + 1'b1)  : {1'b0, low_next};

    two_buckets = {1'b0, buckets, 1'b0};
    adv_sum     = (POINT_BITS+2)'(remainder_eff) + (POINT_BITS+2)'({step_rem_eff, 1'b0});
    adv_carry   = adv_sum >= two_buckets;
    adv_wrapped = adv_carry ? (adv_sum - two_buckets) : adv_sum;
    counter_inc = {1'b0, counter_eff} + 1'b1;
  end

  assign s_axis_tready = status.ready && (!out_valid || m_axis_tready || !emit_now);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter     <= '0;
      bucket_counter     <= '0;
      next_boundary      <= '0;
      boundary_remainder <= '0;
      step_quotient      <= '0;
      step_remainder     <= '0;
      bucket_low         <= MOST_POS;
      bucket_high        <= MOST_NEG;
      running_min        <= MOST_POS;
      running_max        <= MOST_NEG;
    end else if (in_accept) begin
      if (sample_counter != CNT_MAX) begin
        sample_counter <= sample_counter + 1'b1;
      end
      if (in_window) begin
        step_quotient  <= quotient_eff;
        step_remainder <= step_rem_eff;
        if (emit_now) begin
          bucket_counter     <= counter_inc[POINT_BITS-1:0];
          next_boundary      <= boundary_eff + quotient_eff + INDEX_BITS'(adv_carry);
          boundary_remainder <= adv_wrapped[POINT_BITS:0];
          bucket_low         <= MOST_POS;
          bucket_high        <= MOST_NEG;
          running_min        <= rmin_next;
          running_max        <= rmax_next;
        end else begin
          bucket_counter     <= counter_eff;
          next_boundary      <= boundary_eff;
          boundary_remainder <= remainder_eff;
          bucket_low         <= low_next;
          bucket_high        <= high_next;
          running_min        <= rmin_eff;
          running_max        <= rmax_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && emit_now) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit_now) begin
      peak_q       <= (high_mag >= low_mag) ? high_next : low_next;
      bucket_q     <= counter_eff;
      last_q       <= counter_inc == {1'b0, buckets};
      window_min_q <= rmin_next;
      window_max_q <= rmax_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = OUT_DATA_BITS'({window_max_q, window_min_q, bucket_q, peak_q});

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |-> !(in_accept && emit_now))
    else $error("Pending point would be overwritten.");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (sample_counter == $past(sample_counter) + 1'b1) ||
                  (sample_counter == CNT_MAX))
    else $error("Sample counter did not advance by one word.");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_min_q <= window_max_q))
    else $error("Window minimum exceeds window maximum.");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for peak_preserving_decimator: streams sample words through
// a sequence of window settings and checks each point against an in-bench predictor.
// Depends on ppd_pkg and the peak_preserving_decimator RTL.
`timescale 1ns / 1ps

module tb;
  import ppd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int SAMPLE_TARGET = 800;
  localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;

  typedef struct {
    logic signed [31:0] peak;
    logic [15:0]        bucket;
    logic               last;
    logic signed [31:0] low;
    logic signed [31:0] high;
  } point_t;

  class peak_tracker;
    logic [23:0]        trace_len;
    logic signed [24:0] first_idx;
    logic signed [24:0] end_idx;
    logic [15:0]        max_pts;
    logic [23:0]        sample_count;
    logic [23:0]        boundary;
    logic [23:0]        step_q;
    logic [16:0]        bound_rem;
    logic [16:0]        step_r;
    logic [15:0]        bucket_idx;
    logic signed [31:0] bkt_low;
    logic signed [31:0] bkt_high;
    logic signed [31:0] win_min;
    logic signed [31:0] win_max;
    point_t             expected_points[$];
    int                 mismatches;
    int                 points_checked;

    function new();
      trace_len = '0;
      first_idx = '0;
      end_idx = '0;
      max_pts = 16'(MAX_POINTS_RESET);
      sample_count = '0;
      boundary = '0;
      step_q = '0;
      bound_rem = '0;
      step_r = '0;
      bucket_idx = '0;
      bkt_low = MOST_POS;
      bkt_high = MOST_NEG;
      win_min = MOST_POS;
      win_max = MOST_NEG;
      mismatches = 0;
      points_checked = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [24:0] value);
      case (idx)
        REG_TRACE_LENGTH: trace_len = value[23:0];
        REG_FIRST_INDEX:  first_idx = value;
        REG_END_INDEX:    end_idx = value;
        REG_MAX_POINTS:   max_pts = value[15:0];
        default: ;
      endcase
    endfunction

    function void step_boundary(longint nbuckets);
      longint r;
      r = longint'(bound_rem) + 2 * longint'(step_r);
      boundary = boundary + step_q;
      if (r >= 2 * nbuckets) begin
        r = r - 2 * nbuckets;
        boundary = boundary + 24'd1;
      end
      bound_rem = r[16:0];
    endfunction

    function void take_sample(logic signed [31:0] s);
      longint lo;
      longint hi;
      longint k;
      longint span;
      longint nbuckets;
      longint mag_hi;
      longint mag_lo;
      point_t p;
      lo = first_idx;
      if (lo < 0) lo = 0;
      hi = end_idx;
      if (hi > longint'(trace_len)) hi = longint'(trace_len);
      k = longint'(sample_count);
      if (hi > lo && max_pts != 0 && k >= lo && k < hi) begin
        span = hi - lo;
        nbuckets = (longint'(max_pts) < span) ? longint'(max_pts) : span;
        if (k == lo) begin
          step_q = 24'(span / nbuckets);
          step_r = 17'(span % nbuckets);
          boundary = 24'(lo);
          bound_rem = 17'(nbuckets);
          step_boundary(nbuckets);
          bucket_idx = '0;
          bkt_low = MOST_POS;
          bkt_high = MOST_NEG;
          win_min = MOST_POS;
          win_max = MOST_NEG;
        end
        if (s < bkt_low) bkt_low = s;
        if (s > bkt_high) bkt_high = s;
        if (k + 1 == longint'(boundary)) begin
          mag_hi = bkt_high;
          if (mag_hi < 0) mag_hi = -mag_hi;
          mag_lo = bkt_low;
          if (mag_lo < 0) mag_lo = -mag_lo;
          if (bkt_low < win_min) win_min = bkt_low;
          if (bkt_high > win_max) win_max = bkt_high;
          p.peak = (mag_hi >= mag_lo) ? bkt_high : bkt_low;
          p.bucket = bucket_idx;
          p.last = (longint'(bucket_idx) + 1 == nbuckets);
          p.low = win_min;
          p.high = win_max;
          expected_points.push_back(p);
          bucket_idx = bucket_idx + 16'd1;
          step_boundary(nbuckets);
          bkt_low = MOST_POS;
          bkt_high = MOST_NEG;
        end
      end
      if (sample_count != '1) sample_count = sample_count + 24'd1;
    endfunction

    function void check_point(point_t got);
      point_t want;
      points_checked++;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected point peak=%0d bucket=%0d last=%0b min=%0d max=%0d",
                   got.peak, got.bucket, got.last, got.low, got.high);
        return;
      end
      want = expected_points.pop_front();
      if (got.peak !== want.peak || got.bucket !== want.bucket || got.last !== want.last ||
          got.low !== want.low || got.high !== want.high) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("tb: point mismatch, expected peak=%0d bucket=%0d last=%0b min=%0d max=%0d",
                   want.peak, want.bucket, want.last, want.low, want.high);
          $display("tb:                 actual   peak=%0d bucket=%0d last=%0b min=%0d max=%0d",
                   got.peak, got.bucket, got.last, got.low, got.high);
        end
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [31:0]               s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [111:0]              m_axis_tdata;
  logic                      m_axis_tlast;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [24:0]               cfg_data = '0;

  peak_tracker sb;
  int cycles = 0;
  int send_idle = 28;
  int recv_idle = 68;
  int samples_sent = 0;
  int settings_used = 0;

  always #4 clk = ~clk;

  peak_preserving_decimator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_point('{m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tlast,
                         m_axis_tdata[79:48], m_axis_tdata[111:80]});
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_points.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [24:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.set_register(idx, value);
  endtask

  task automatic set_window(int length, int start_idx, int stop, int points);
    wait_idle();
    write_reg(REG_TRACE_LENGTH, 25'(length));
    write_reg(REG_FIRST_INDEX, 25'(start_idx));
    write_reg(REG_END_INDEX, 25'(stop));
    write_reg(REG_MAX_POINTS, 25'(points));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_sample(logic signed [31:0] v);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    sb.take_sample(v);
    samples_sent++;
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return MOST_POS;
          1: return MOST_NEG;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0000_0000;
          4: return 32'h0000_0001;
          default: return 32'h8000_0001;
        endcase
      end
      1, 2, 3: return 32'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  // Most settings open a fresh window just ahead of the sample counter; the rest leave
  // the window empty, cut it short, or place its start behind the counter.
  task automatic random_phase();
    int c;
    int kind;
    int offset;
    int span;
    int start_idx;
    int stop;
    int length;
    int points;
    int count;
    c = int'(sb.sample_count);
    kind = $urandom_range(0, 9);
    offset = $urandom_range(0, 6);
    span = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 200) : $urandom_range(1, 48);
    start_idx = c + offset;
    stop = start_idx + span;
    case ($urandom_range(0, 4))
      0: points = 65535;
      1: points = 1;
      2: points = span;
      3: points = $urandom_range(1, span);
      default: points = $urandom_range(span, span + 20);
    endcase
    case ($urandom_range(0, 3))
      0: length = stop;
      1: begin
        length = stop;
        stop = 16777215;
      end
      2: length = 16777215;
      default: length = stop + $urandom_range(1, 50);
    endcase
    count = offset + span + $urandom_range(0, 3);
    if (kind == 0) begin
      case ($urandom_range(0, 3))
        0: points = 0;
        1: length = 0;
        2: stop = start_idx - $urandom_range(0, 5);
        default: start_idx = stop;
      endcase
      count = $urandom_range(2, 8);
    end else if (kind == 1) begin
      count = $urandom_range(1, offset + span);
    end else if (kind == 2) begin
      start_idx = -int'($urandom_range(1, 16777216));
      count = span;
    end
    set_window(length, start_idx, stop, points);
    repeat (count) send_sample(pick_sample());
  endtask

  logic [31:0] directed_words[18] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
    32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0000,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
    32'hFFFF_FFF9, 32'h8000_0001, 32'h7FFF_FFFF,
    32'h0000_007B, 32'hFFFF_FF85
  };

  initial begin
    int c;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Sixteen samples in five uneven buckets, the last two words fall past the window.
    set_window(16, -16777216, 16777215, 5);
    foreach (directed_words[i]) send_sample(directed_words[i]);

    // Each way of leaving the window empty, one word apiece.
    for (int sub = 0; sub < 4; sub++) begin
      c = int'(sb.sample_count);
      case (sub)
        0: set_window(c + 10, c, c + 5, 0);
        1: set_window(0, c, c + 5, 7);
        2: set_window(c + 10, c, -16777216, 7);
        default: set_window(16777215, 16777215, 16777215, 65535);
      endcase
      send_sample(pick_sample());
    end

    while (samples_sent < SAMPLE_TARGET) begin
      if (samples_sent < 270) begin
        send_idle = 28;
        recv_idle = 68;
      end else if (samples_sent < 540) begin
        send_idle = 68;
        recv_idle = 28;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      random_phase();
    end

    wait_idle();
    $display("tb: %0d sample words over %0d window settings, %0d points checked",
             samples_sent, settings_used, sb.points_checked);
    $display("tb: %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
